@@ rtl/core/iprt_pkg.sv @@
// Shared types, constants and helpers of the IPv6 fragment reassembly tracker.
package iprt_pkg;

   localparam int CONTEXTS          = 16;
   localparam int FRAGS_PER_CONTEXT = 8;

   localparam int IDX_W  = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
   localparam int CNT_W  = $clog2(FRAGS_PER_CONTEXT + 1);
   localparam int RDEPTH = CONTEXTS * FRAGS_PER_CONTEXT;
   localparam int A_W    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
   localparam int SUM_W  = 16 + CNT_W;

   localparam logic [2:0] RS_PENDING  = 3'd0;
   localparam logic [2:0] RS_COMPLETE = 3'd1;
   localparam logic [2:0] RS_TBL_FULL = 3'd2;
   localparam logic [2:0] RS_LST_FULL = 3'd3;
   localparam logic [2:0] RS_EXPIRED  = 3'd4;

   localparam logic CMD_FRAG = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic [31:0] ident;
      logic [63:0] dst_lo;
      logic [63:0] dst_hi;
      logic [63:0] src_lo;
      logic [63:0] src_hi;
   } key_type;

   typedef struct packed {
      logic        cmd;
      logic [15:0] frag_offset;
      logic [15:0] data_len;
      logic        more_frags;
      logic [7:0]  next_header;
   } item_type;

   typedef struct packed {
      logic             wr;
      logic [IDX_W-1:0] idx;
   } key_req_type;

   typedef struct packed {
      logic           we;
      logic [A_W-1:0] addr;
      logic [31:0]    wdata;
   } ram_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [16:0] total_length;
      logic [7:0]  out_next_header;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_CHECK, S_FIND, S_FIND_CMP, S_SHIFT, S_SHIFT_WR,
      S_INSERT, S_WALK, S_WALK_CMP, S_FINISH, S_TICK, S_EMIT, S_OUT
   } st_type;

   function automatic logic [A_W-1:0] rng_addr(logic [IDX_W-1:0] c, logic [CNT_W-1:0] i);
      return A_W'(A_W'(c) * A_W'(FRAGS_PER_CONTEXT) + A_W'(i));
   endfunction

   function automatic logic [3:0] slot_of(logic [IDX_W-1:0] c);
      logic [IDX_W+3:0] w;
      w = {4'd0, c};
      return w[3:0];
   endfunction

endpackage

@@ rtl/core/ipv6_fragment_reassembly_tracker_top.sv @@
// Top level of the IPv6 fragment reassembly tracker.
// Usage:
//   req_ channel: one beat is either a fragment (tuser[0] = 0) carrying the
//   flow key, offset, length, more-fragments flag and next header, or a
//   timer tick (tuser[0] = 1) that ages every open context.
//   rsp_ channel: a fragment yields exactly one beat (pending, complete,
//   table full or list full); a tick yields one expired beat per expiring
//   context in slot order, or none. rsp_tlast marks the final beat.
//   csr_wen/csr_wdata write timeout_ticks; write only while idle.
// Sequence:
//   A fragment runs a key compare over every context through the single
//   compare unit, picks the context, checks its list, runs the sorted-insert
//   search and shift through the one-port range RAM, inserts, walks the
//   list for gaps and finishes; a full table or a full list ends the
//   sequence early with its beat.
//   A tick ages every context, then steps through the slots up to the last
//   expiring one, holding each expired beat until it is taken.
// Reset clears all contexts and loads timeout_ticks with 60. req_tready is
// high only while idle, between sequences; a stalled rsp_ beat holds until
// it is taken.
module ipv6_fragment_reassembly_tracker_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [327:0] req_tdata,  // src_hi, src_lo, dst_hi, dst_lo, ident, frag_offset,
                                    // data_len, next_header
   input  logic [1:0]   req_tuser,  // cmd, more_frags
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,  // slot, total_length, out_next_header, zero pad
   output logic [2:0]   rsp_tuser,  // status
   output logic         rsp_tlast,
   input  logic         csr_wen,
   input  logic [15:0]  csr_wdata
);
   import iprt_pkg::*;

   logic      accept, idle;
   key_type   key_ff, key_in;
   item_type  item_ff, item_in;
   key_req_type key_req;
   ram_req_type ram_req;
   logic      key_match;
   logic [31:0] ram_rdata;
   rsp_type   rsp;

   assign req_tready = idle;
   assign accept     = req_tvalid && req_tready;

   // capture the beat; hold it for the whole sequence
   always_comb begin
      key_in  = key_ff;
      item_in = item_ff;
      if (accept) begin
         key_in  = '{src_hi: req_tdata[63:0], src_lo: req_tdata[127:64],
                     dst_hi: req_tdata[191:128], dst_lo: req_tdata[255:192],
                     ident: req_tdata[287:256]};
         item_in = '{cmd: req_tuser[0], frag_offset: req_tdata[303:288],
                     data_len: req_tdata[319:304], more_frags: req_tuser[1],
                     next_header: req_tdata[327:320]};
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      item_ff <= item_in;
   end

   iprt_ctx_table u_table (
      .clock (clock),
      .req   (key_req),
      .key   (key_ff),
      .match (key_match)
   );

   iprt_range_ram u_ram (
      .clock (clock),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

   iprt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .accept_cmd (req_tuser[0]),
      .item       (item_ff),
      .idle       (idle),
      .key_req    (key_req),
      .key_match  (key_match),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_taken  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {3'd0, rsp.out_next_header, rsp.total_length, rsp.slot};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;
endmodule

@@ rtl/core/iprt_range_ram.sv @@
// Fragment range store: one write or read address per cycle, registered read.
module iprt_range_ram (
   input  logic                 clock,
   input  iprt_pkg::ram_req_type req,
   output logic [31:0]          rdata
);
   import iprt_pkg::*;

   logic [31:0] mem [RDEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      rdata_ff <= mem[req.addr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/core/iprt_ctx_table.sv @@
// Flow key store with the shared key compare unit.
module iprt_ctx_table (
   input  logic                  clock,
   input  iprt_pkg::key_req_type req,
   input  iprt_pkg::key_type     key,
   output logic                  match
);
   import iprt_pkg::*;

   key_type keys_ff [CONTEXTS];

   always_ff @(posedge clock) begin
      if (req.wr) begin
         keys_ff[req.idx] <= key;
      end
   end

   // compare one stored key per cycle
   assign match = (keys_ff[req.idx] == key);
endmodule

@@ rtl/core/iprt_ctrl.sv @@
// Sequencer: context scan, sorted insert, gap walk, aging and result staging.
module iprt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [15:0]           csr_wdata,
   input  logic                  accept,
   input  logic                  accept_cmd,
   input  iprt_pkg::item_type    item,
   output logic                  idle,
   output iprt_pkg::key_req_type key_req,
   input  logic                  key_match,
   output iprt_pkg::ram_req_type ram_req,
   input  logic [31:0]           ram_rdata,
   output logic                  rsp_valid,
   input  logic                  rsp_taken,
   output iprt_pkg::rsp_type     rsp
);
   import iprt_pkg::*;

   st_type state_ff, state_in;

   logic [15:0]      timeout_ff, timeout_in;
   logic             valid_ff [CONTEXTS];
   logic             valid_in [CONTEXTS];
   logic [15:0]      age_ff   [CONTEXTS];
   logic [17:0]      total_ff [CONTEXTS];
   logic [CNT_W-1:0] count_ff [CONTEXTS];
   logic [7:0]       nh_ff    [CONTEXTS];

   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             found_v_ff, found_v_in, free_v_ff, free_v_in;
   logic [IDX_W-1:0] found_ff, found_in, free_ff, free_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, pos_ff, pos_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             gap_ff, gap_in, tick_ff, tick_in;
   logic [CONTEXTS-1:0] mask_ff, mask_in;
   rsp_type          rsp_ff, rsp_in;

   // per-context write strobes
   logic             ctx_we, alloc_we, age_we, cnt_we;
   logic [IDX_W-1:0] ctx_idx;
   logic [7:0]       nh_wval;
   logic             tot_we;
   logic [17:0]      tot_wval;
   logic [15:0]      age_wval;
   logic [CNT_W-1:0] cnt_wval;

   logic             last_idx;
   logic [15:0]      rd_off, rd_len, age_next;
   logic [CNT_W-1:0] cur_cnt;
   logic [CONTEXTS-1:0] mask_rest;

   assign last_idx  = (32'(cur_ff) == CONTEXTS - 1);
   assign rd_off    = ram_rdata[31:16];
   assign rd_len    = ram_rdata[15:0];
   assign cur_cnt   = count_ff[cur_ff];
   assign age_next  = (age_ff[cur_ff] == 16'hFFFF) ? 16'hFFFF : age_ff[cur_ff] + 16'd1;
   assign mask_rest = mask_ff & ~(CONTEXTS'(1) << cur_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (accept) state_in = (accept_cmd == CMD_TICK) ? S_TICK : S_SCAN;
         S_SCAN:     if (last_idx) state_in = S_DECIDE;
         S_DECIDE:   state_in = (found_v_ff || free_v_ff) ? S_CHECK : S_OUT;
         S_CHECK:    state_in = (32'(cur_cnt) >= FRAGS_PER_CONTEXT) ? S_OUT : S_FIND;
         S_FIND:     state_in = (i_ff == cur_cnt) ? S_SHIFT : S_FIND_CMP;
         S_FIND_CMP: state_in = (item.frag_offset > rd_off) ? S_FIND : S_SHIFT;
         S_SHIFT:    state_in = (j_ff == pos_ff) ? S_INSERT : S_SHIFT_WR;
         S_SHIFT_WR: state_in = S_SHIFT;
         S_INSERT:   state_in = S_WALK;
         S_WALK:     state_in = (i_ff == cur_cnt) ? S_FINISH : S_WALK_CMP;
         S_WALK_CMP: state_in = (SUM_W'(rd_off) > sum_ff) ? S_FINISH : S_WALK;
         S_FINISH:   state_in = S_OUT;
         S_TICK:     if (last_idx) state_in = S_EMIT;
         S_EMIT: begin
            if (mask_ff == '0) state_in = S_IDLE;
            else if (mask_ff[cur_ff]) state_in = S_OUT;
         end
         S_OUT:      if (rsp_taken) state_in = tick_ff ? S_EMIT : S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      timeout_in = csr_wen ? csr_wdata : timeout_ff;
      valid_in   = valid_ff;
      cur_in     = cur_ff;
      found_v_in = found_v_ff;
      found_in   = found_ff;
      free_v_in  = free_v_ff;
      free_in    = free_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      gap_in     = gap_ff;
      tick_in    = tick_ff;
      mask_in    = mask_ff;
      rsp_in     = rsp_ff;
      ctx_we     = 1'b0;
      alloc_we   = 1'b0;
      age_we     = 1'b0;
      cnt_we     = 1'b0;
      tot_we     = 1'b0;
      ctx_idx    = cur_ff;
      nh_wval    = item.next_header;
      tot_wval   = {1'b1, 17'(item.frag_offset) + 17'(item.data_len)};
      age_wval   = age_next;
      cnt_wval   = cur_cnt + CNT_W'(1);
      key_req    = '{wr: 1'b0, idx: cur_ff};
      ram_req    = '{we: 1'b0, addr: rng_addr(cur_ff, i_ff), wdata: ram_rdata};

      unique case (state_ff)
         S_IDLE: begin
            cur_in     = '0;
            found_v_in = 1'b0;
            free_v_in  = 1'b0;
            mask_in    = '0;
            tick_in    = (accept_cmd == CMD_TICK);
         end
         S_SCAN: begin
            if (valid_ff[cur_ff]) begin
               if (!found_v_ff && key_match) begin
                  found_v_in = 1'b1;
                  found_in   = cur_ff;
               end
            end else if (!free_v_ff) begin
               free_v_in = 1'b1;
               free_in   = cur_ff;
            end
            cur_in = cur_ff + IDX_W'(1);
         end
         S_DECIDE: begin
            if (found_v_ff) begin
               cur_in = found_ff;
            end else if (free_v_ff) begin
               cur_in            = free_ff;
               alloc_we          = 1'b1;
               ctx_idx           = free_ff;
               valid_in[free_ff] = 1'b1;
               key_req           = '{wr: 1'b1, idx: free_ff};
            end else begin
               rsp_in = '{status: RS_TBL_FULL, slot: 4'd0, total_length: 17'd0,
                          out_next_header: 8'd0, last: 1'b1};
            end
         end
         S_CHECK: begin
            i_in = '0;
            if (32'(cur_cnt) >= FRAGS_PER_CONTEXT) begin
               rsp_in = '{status: RS_LST_FULL, slot: slot_of(cur_ff), total_length: 17'd0,
                          out_next_header: nh_ff[cur_ff], last: 1'b1};
            end else begin
               ctx_we = 1'b1;
               tot_we = !item.more_frags;
            end
         end
         S_FIND: begin
            if (i_ff == cur_cnt) begin
               pos_in = i_ff;
               j_in   = cur_cnt;
            end
         end
         S_FIND_CMP: begin
            if (item.frag_offset > rd_off) begin
               i_in = i_ff + CNT_W'(1);
            end else begin
               pos_in = i_ff;
               j_in   = cur_cnt;
            end
         end
         S_SHIFT: begin
            ram_req.addr = rng_addr(cur_ff, j_ff - CNT_W'(1));
         end
         S_SHIFT_WR: begin
            ram_req = '{we: 1'b1, addr: rng_addr(cur_ff, j_ff), wdata: ram_rdata};
            j_in    = j_ff - CNT_W'(1);
         end
         S_INSERT: begin
            ram_req = '{we: 1'b1, addr: rng_addr(cur_ff, pos_ff),
                        wdata: {item.frag_offset, item.data_len}};
            cnt_we  = 1'b1;
            i_in    = '0;
            sum_in  = '0;
            gap_in  = 1'b0;
         end
         S_WALK: begin
         end
         S_WALK_CMP: begin
            if (SUM_W'(rd_off) > sum_ff) begin
               gap_in = 1'b1;
            end else begin
               sum_in = sum_ff + SUM_W'(rd_len);
               i_in   = i_ff + CNT_W'(1);
            end
         end
         S_FINISH: begin
            if (total_ff[cur_ff][17] && !gap_ff) begin
               rsp_in = '{status: RS_COMPLETE, slot: slot_of(cur_ff),
                          total_length: total_ff[cur_ff][16:0],
                          out_next_header: nh_ff[cur_ff], last: 1'b1};
               valid_in[cur_ff] = 1'b0;
            end else begin
               rsp_in = '{status: RS_PENDING, slot: slot_of(cur_ff), total_length: 17'd0,
                          out_next_header: nh_ff[cur_ff], last: 1'b1};
            end
         end
         S_TICK: begin
            if (valid_ff[cur_ff]) begin
               age_we = 1'b1;
               if (age_next >= timeout_ff) begin
                  valid_in[cur_ff] = 1'b0;
                  mask_in[cur_ff]  = 1'b1;
               end
            end
            cur_in = cur_ff + IDX_W'(1);
         end
         S_EMIT: begin
            if (mask_ff != '0) begin
               if (mask_ff[cur_ff]) begin
                  rsp_in = '{status: RS_EXPIRED, slot: slot_of(cur_ff), total_length: 17'd0,
                             out_next_header: nh_ff[cur_ff], last: (mask_rest == '0)};
                  mask_in = mask_rest;
               end
               cur_in = cur_ff + IDX_W'(1);
            end
         end
         S_OUT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         timeout_ff <= 16'd60;
         for (int c = 0; c < CONTEXTS; c++) valid_ff[c] <= 1'b0;
      end else begin
         state_ff   <= state_in;
         timeout_ff <= timeout_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      found_v_ff <= found_v_in;
      found_ff   <= found_in;
      free_v_ff  <= free_v_in;
      free_ff    <= free_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      pos_ff     <= pos_in;
      sum_ff     <= sum_in;
      gap_ff     <= gap_in;
      tick_ff    <= tick_in;
      mask_ff    <= mask_in;
      rsp_ff     <= rsp_in;
      if (alloc_we) begin
         total_ff[ctx_idx] <= '0;
         age_ff[ctx_idx]   <= '0;
         count_ff[ctx_idx] <= '0;
         nh_ff[ctx_idx]    <= '0;
      end
      if (ctx_we) nh_ff[ctx_idx] <= nh_wval;
      if (tot_we) total_ff[ctx_idx] <= tot_wval;
      if (age_we) age_ff[ctx_idx] <= age_wval;
      if (cnt_we) count_ff[ctx_idx] <= cnt_wval;
   end

   assign idle      = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp       = rsp_ff;
endmodule

@@ rtl/core/iprt_checker.sv @@
// Port-level checks of the tracker, bound to the top level.
module iprt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import iprt_pkg::*;

   // no new beat is taken while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input taken while result pending");

   // hold a stalled result beat
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // fragment results are always single beats
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != RS_EXPIRED |-> rsp_tlast)
      else $error("fragment result without last");

   // only a completion reports a length
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != RS_COMPLETE |-> rsp_tdata[20:4] == 17'd0)
      else $error("length on non-complete result");
endmodule

bind ipv6_fragment_reassembly_tracker_top iprt_checker u_iprt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
